// ===== design/jacm_pkg.sv =====
package jacm_pkg;

	localparam int NUM_AXES = 8;
	localparam int IDX_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int AXE_W    = 5;	// axis number widened so it can hold NUM_AXES

	localparam int CMD_W  = 3;
	localparam int AXIS_W = 3;
	localparam int SAMP_W = 10;
	localparam int OUT_W  = 16;
	localparam int AIU_W  = 4;

	localparam logic [SAMP_W-1:0] RAW_TOP = 10'd1023;
	localparam logic [SAMP_W-1:0] RAW_MID = 10'd512;

	// Map arithmetic widths.
	localparam int SPAN_W = SAMP_W + 2;		// signed sample differences
	localparam int OR_W   = OUT_W + 2;		// signed output range ends and range
	localparam int PROD_W = SPAN_W + OR_W;		// signed product
	localparam int NUM_W  = 27;			// product magnitude
	localparam int DEN_W  = SAMP_W + 1;		// span magnitude
	localparam int VAL_W  = NUM_W + 2;		// signed value before the clamp
	localparam int CNT_W  = $clog2(NUM_W + 1);

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET  = 3'd0,
		CMD_TRACK  = 3'd1,
		CMD_CENTER = 3'd2,
		CMD_READ   = 3'd3,
		CMD_LOAD   = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXES       = 2'd0,
		CFG_OUT_MIN    = 2'd1,
		CFG_OUT_CENTER = 2'd2,
		CFG_OUT_MAX    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [AIU_W-1:0]        axes;
		logic signed [OUT_W-1:0] out_min;
		logic signed [OUT_W-1:0] out_center;
		logic signed [OUT_W-1:0] out_max;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic div_start;
		logic fin;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_map;
		logic need_div;
		logic div_busy;
	} dp_sts_t;

endpackage

// ===== design/joystick_axis_calibrate_map.sv =====
// A read that needs the divider goes from acceptance through execute, divider load, the
// one-bit-per-cycle divider, finish and done; a read exactly at the centre or over a flat span
// skips the divider, and every other word goes from execute straight to done.
// A new word is accepted the cycle after the previous result enters the output register; a
// result still waiting in that register holds it off.
// Reset is asynchronous and returns bounds, centres, mapped values, the calibrated flag and the
// configuration to their reset values at once; there is no clearing pass.
module joystick_axis_calibrate_map
	import jacm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [CMD_W-1:0]            command,
	input  logic [AXIS_W-1:0]           axis,
	input  logic [SAMP_W-1:0]           sample,
	input  logic [SAMP_W-1:0]           load_low,
	input  logic [SAMP_W-1:0]           load_mid,
	input  logic [SAMP_W-1:0]           load_high,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [OUT_W-1:0]     axis_value,
	output logic                        is_calibrated,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [OUT_W-1:0]            cfg_data
);

	cfg_t      cfg_q;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axes       <= AIU_W'(NUM_AXES);
			cfg_q.out_min    <= -16'sd127;
			cfg_q.out_center <= '0;
			cfg_q.out_max    <= 16'sd127;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AXES:       cfg_q.axes       <= cfg_data[AIU_W-1:0];
				CFG_OUT_MIN:    cfg_q.out_min    <= cfg_data;
				CFG_OUT_CENTER: cfg_q.out_center <= cfg_data;
				CFG_OUT_MAX:    cfg_q.out_max    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	jacm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	jacm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.command       (command),
		.axis          (axis),
		.sample        (sample),
		.load_low      (load_low),
		.load_mid      (load_mid),
		.load_high     (load_high),
		.axis_value    (axis_value),
		.is_calibrated (is_calibrated)
	);

endmodule

// ===== design/jacm_div.sv =====
module jacm_div
	import jacm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             take;
	logic [DEN_W-1:0] rem_nx;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		trial  = {rem_q, quo_q[NUM_W-1]};
		diff   = trial - {1'b0, den_q};
		take   = (trial >= {1'b0, den_q});
		rem_nx = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== design/jacm_dp.sv =====
module jacm_dp
	import jacm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  ctrl_cmd_t                cmd,
	output dp_sts_t                  sts,
	input  logic [CMD_W-1:0]         command,
	input  logic [AXIS_W-1:0]        axis,
	input  logic [SAMP_W-1:0]        sample,
	input  logic [SAMP_W-1:0]        load_low,
	input  logic [SAMP_W-1:0]        load_mid,
	input  logic [SAMP_W-1:0]        load_high,
	output logic signed [OUT_W-1:0]  axis_value,
	output logic                     is_calibrated
);

	// Word held while it is worked on.
	logic [CMD_W-1:0]  cmd_q;
	logic [AXIS_W-1:0] axis_q;
	logic [SAMP_W-1:0] sample_q;
	logic [SAMP_W-1:0] ld_lo_q;
	logic [SAMP_W-1:0] ld_mid_q;
	logic [SAMP_W-1:0] ld_hi_q;

	logic [SAMP_W-1:0]       lb_q  [NUM_AXES];
	logic [SAMP_W-1:0]       ub_q  [NUM_AXES];
	logic [SAMP_W-1:0]       ctr_q [NUM_AXES];
	logic signed [OUT_W-1:0] map_q [NUM_AXES];
	logic                    cal_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [SPAN_W-1:0] span_q;
	logic signed [OR_W-1:0]   olo_q;
	logic signed [OR_W-1:0]   ohi_q;
	logic                     eq_q;
	logic                     zspan_q;
	logic                     neg_q;

	logic signed [OUT_W-1:0] val_q;
	logic                    calo_q;

	logic [AXE_W-1:0]  axis_ext;
	logic [IDX_W-1:0]  idx;
	logic              live;
	logic [SAMP_W-1:0] lb_r;
	logic [SAMP_W-1:0] ub_r;
	logic [SAMP_W-1:0] ctr_r;
	logic              above;
	logic              eq;
	logic signed [SPAN_W-1:0] diff;
	logic signed [SPAN_W-1:0] span;
	logic signed [OR_W-1:0]   oc_x;
	logic signed [OR_W-1:0]   olo;
	logic signed [OR_W-1:0]   ohi;
	logic signed [OR_W-1:0]   rng;
	logic signed [PROD_W-1:0] prod;

	logic [PROD_W-1:0] prod_abs;
	logic [SPAN_W-1:0] span_abs;
	logic [NUM_W-1:0]  quo;
	logic              div_busy;

	logic signed [VAL_W-1:0] qs;
	logic signed [VAL_W-1:0] vraw;
	logic signed [VAL_W-1:0] vmin;
	logic signed [VAL_W-1:0] vmax;
	logic signed [OUT_W-1:0] vclamp;

	always_comb begin
		axis_ext = AXE_W'(axis_q);
		idx      = axis_ext[IDX_W-1:0];
		live     = ({1'b0, axis_q} < cfg.axes) && (axis_ext < AXE_W'(NUM_AXES));
		lb_r     = lb_q[idx];
		ub_r     = ub_q[idx];
		ctr_r    = ctr_q[idx];
		above    = (sample_q > ctr_r);
		eq       = (sample_q == ctr_r);
		oc_x     = {{(OR_W-OUT_W){cfg.out_center[OUT_W-1]}}, cfg.out_center};
		if (above) begin
			diff = SPAN_W'(sample_q) - SPAN_W'(ctr_r);
			span = SPAN_W'(ub_r) - SPAN_W'(ctr_r);
			olo  = oc_x + OR_W'(1);
			ohi  = {{(OR_W-OUT_W){cfg.out_max[OUT_W-1]}}, cfg.out_max};
		end else begin
			diff = SPAN_W'(sample_q) - SPAN_W'(lb_r);
			span = SPAN_W'(ctr_r) - SPAN_W'(lb_r);
			olo  = {{(OR_W-OUT_W){cfg.out_min[OUT_W-1]}}, cfg.out_min};
			ohi  = oc_x - OR_W'(1);
		end
		rng  = ohi - olo;
		prod = diff * rng;
	end

	assign sts.need_map = (cmd_q == CMD_READ) && live && cal_q;
	assign sts.need_div = sts.need_map && !eq && (span != '0);
	assign sts.div_busy = div_busy;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q    <= command;
			axis_q   <= axis;
			sample_q <= sample;
			ld_lo_q  <= load_low;
			ld_mid_q <= load_mid;
			ld_hi_q  <= load_high;
		end
		if (cmd.exec) begin
			prod_q  <= prod;
			span_q  <= span;
			olo_q   <= olo;
			ohi_q   <= ohi;
			eq_q    <= eq;
			zspan_q <= (span == '0);
		end
		if (cmd.div_start) begin
			neg_q <= prod_q[PROD_W-1] ^ span_q[SPAN_W-1];
		end
		if (cmd.load_out) begin
			val_q  <= live ? map_q[idx] : cfg.out_center;
			calo_q <= cal_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				lb_q[i]  <= RAW_TOP;
				ub_q[i]  <= '0;
				ctr_q[i] <= RAW_MID;
				map_q[i] <= '0;
			end
			cal_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (cmd_q == CMD_RESET) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						lb_q[i] <= RAW_TOP;
						ub_q[i] <= '0;
					end
				end else if (live) begin
					unique case (cmd_q)
						CMD_TRACK: begin
							if (sample_q > ub_r) begin
								ub_q[idx] <= sample_q;
							end
							if (sample_q < lb_r) begin
								lb_q[idx] <= sample_q;
							end
						end
						CMD_CENTER: begin
							ctr_q[idx] <= sample_q;
							cal_q      <= 1'b1;
						end
						CMD_LOAD: begin
							lb_q[idx]  <= ld_lo_q;
							ctr_q[idx] <= ld_mid_q;
							ub_q[idx]  <= ld_hi_q;
							cal_q      <= 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			if (cmd.fin) begin
				map_q[idx] <= vclamp;
			end
		end
	end

	always_comb begin
		prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		span_abs = span_q[SPAN_W-1] ? SPAN_W'(-span_q) : SPAN_W'(span_q);
	end

	jacm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_abs[NUM_W-1:0]),
		.den    (span_abs[DEN_W-1:0]),
		.busy   (div_busy),
		.quo    (quo)
	);

	// Final value, clamped to the output range: a read exactly at the centre and a zero span bypass the divider.
	always_comb begin
		qs   = neg_q ? -VAL_W'(quo) : VAL_W'(quo);
		vmin = {{(VAL_W-OUT_W){cfg.out_min[OUT_W-1]}}, cfg.out_min};
		vmax = {{(VAL_W-OUT_W){cfg.out_max[OUT_W-1]}}, cfg.out_max};
		if (eq_q) begin
			vraw = {{(VAL_W-OUT_W){cfg.out_center[OUT_W-1]}}, cfg.out_center};
		end else if (zspan_q) begin
			vraw = {{(VAL_W-OR_W){ohi_q[OR_W-1]}}, ohi_q};
		end else begin
			vraw = qs + {{(VAL_W-OR_W){olo_q[OR_W-1]}}, olo_q};
		end
		priority if (vraw < vmin) begin
			vclamp = cfg.out_min;
		end else if (vraw > vmax) begin
			vclamp = cfg.out_max;
		end else begin
			vclamp = vraw[OUT_W-1:0];
		end
	end

	assign axis_value    = val_q;
	assign is_calibrated = calo_q;

endmodule

// ===== design/jacm_ctrl.sv =====
module jacm_ctrl
	import jacm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output logic      result_valid,
	input  logic      result_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nx;
	logic   rv_q;
	logic   out_free;

	assign out_free = !rv_q || result_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (sts.need_div) begin
					state_nx = ST_LOAD;
				end else if (sts.need_map) begin
					state_nx = ST_FIN;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_LOAD: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.latch  = item_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV: begin
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	assign result_valid = rv_q;

endmodule
